/* rtl/lfau_pkg.sv */
// ----------------------------------------------------------------------------
// lfau_pkg
// Shared types, constants and helpers for the locator frame angle unwrap block.
// ----------------------------------------------------------------------------
package lfau_pkg;

	localparam int                  LFAU_FRAC_BITS  = 16;
	localparam int                  LFAU_FRAME_LEN  = 18;
	localparam int                  LFAU_QDEPTH     = 2;
	localparam logic [7:0]          LFAU_HEAD0      = 8'hBB;
	localparam logic [7:0]          LFAU_HEAD1      = 8'hCC;
	localparam logic [15:0]         LFAU_SCALE_RST  = 16'd500;
	localparam logic signed [63:0]  LFAU_MAX48      = 64'sh0000_7FFF_FFFF_FFFF;
	localparam logic signed [63:0]  LFAU_MIN48      = -64'sh0000_8000_0000_0000;
	localparam logic signed [15:0]  LFAU_TURN_MAX   = 16'sh7FFF;
	localparam logic signed [15:0]  LFAU_TURN_MIN   = -16'sh8000;

	typedef struct packed {
		logic [31:0] hd;
		logic [31:0] py;
		logic [31:0] px;
		logic [31:0] rng;
	} lfau_frame_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIFF,
		ST_MUL
	} lfau_state_t;

	function automatic logic signed [47:0] lfau_sat48(input logic signed [63:0] v);
		logic signed [47:0] r;
		if (v > LFAU_MAX48) begin
			r = LFAU_MAX48[47:0];
		end else if (v < LFAU_MIN48) begin
			r = LFAU_MIN48[47:0];
		end else begin
			r = v[47:0];
		end
		return r;
	endfunction

endpackage

/* rtl/lfau_front.sv */
// ----------------------------------------------------------------------------
// lfau_front
// Byte framer: tracks frame position, checks the header and gathers the
// sixteen payload bytes; hands a finished good frame to the queue.
// ----------------------------------------------------------------------------
module lfau_front
	import lfau_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic [7:0]  rx_byte,
	input  logic        frame_start,
	input  logic        q_full,
	output logic        q_push,
	output lfau_frame_t q_data
);

	logic [4:0]   byte_idx_q;
	logic         hdr_good_q;
	logic [127:0] pay_q;
	logic         acc;
	logic         active;
	logic [4:0]   pos;
	logic         last;
	logic [127:0] pay_next;

	assign acc      = push && !q_full;
	assign active   = frame_start || (byte_idx_q != 5'd0);
	assign pos      = frame_start ? 5'd0 : byte_idx_q;
	assign last     = (pos == 5'(LFAU_FRAME_LEN - 1));
	assign pay_next = {rx_byte, pay_q[127:8]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_idx_q <= 5'd0;
			hdr_good_q <= 1'b0;
		end else if (acc && active) begin
			if (pos == 5'd0) begin
				hdr_good_q <= (rx_byte == LFAU_HEAD0);
			end else if (pos == 5'd1) begin
				hdr_good_q <= hdr_good_q && (rx_byte == LFAU_HEAD1);
			end
			byte_idx_q <= last ? 5'd0 : pos + 5'd1;
		end
	end

	// payload shift line, oldest byte ends up lowest
	always_ff @(posedge clk) begin
		if (acc && active && pos > 5'd1) begin
			pay_q <= pay_next;
		end
	end

	assign q_push = acc && active && last && hdr_good_q;
	assign q_data = lfau_frame_t'(pay_next);

endmodule

/* rtl/lfau_queue.sv */
// ----------------------------------------------------------------------------
// lfau_queue
// Short frame queue between the framer and the arithmetic back end.
// ----------------------------------------------------------------------------
module lfau_queue
	import lfau_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  lfau_frame_t wr_data,
	input  logic        rd_en,
	output lfau_frame_t rd_data,
	output logic        full,
	output logic        empty
);

	localparam int PW = $clog2(LFAU_QDEPTH);

	lfau_frame_t    mem_q [LFAU_QDEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [PW:0]    count_q;
	logic           do_wr;
	logic           do_rd;

	assign full  = (count_q == (PW+1)'(LFAU_QDEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	assign rd_data = mem_q[rd_ptr_q];

endmodule

/* rtl/lfau_back.sv */
// ----------------------------------------------------------------------------
// lfau_back
// Frame arithmetic: float to fixed conversion, differences, heading unwrap,
// scaling and saturation, with the result register on the output side.
// ----------------------------------------------------------------------------
module lfau_back
	import lfau_pkg::*;
#(
	parameter int FRAC_BITS = LFAU_FRAC_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_wdata,
	input  logic                q_empty,
	input  lfau_frame_t         q_data,
	output logic                q_pop,
	input  logic                pop,
	output logic                empty,
	output logic signed [31:0]  range_distance,
	output logic signed [31:0]  position_x,
	output logic signed [31:0]  position_y,
	output logic signed [31:0]  heading,
	output logic signed [47:0]  speed_x,
	output logic signed [47:0]  speed_y,
	output logic signed [47:0]  turn_rate,
	output logic signed [15:0]  turn_count,
	output logic signed [47:0]  unwrapped_heading
);

	localparam logic signed [63:0] HALF   = 64'sd180 <<< FRAC_BITS;
	localparam int                 TK_W   = FRAC_BITS + 10;
	localparam logic signed [TK_W-1:0] TURN_K = TK_W'(64'sd360 <<< FRAC_BITS);

	function automatic logic signed [31:0] to_fixed(input logic [31:0] bits);
		logic        sgn;
		logic [7:0]  ex;
		logic [23:0] man;
		logic [31:0] mag;
		logic [31:0] r;
		int          sh;
		sgn = bits[31];
		ex  = bits[30:23];
		man = {1'b1, bits[22:0]};
		sh  = int'(ex) - 150 + FRAC_BITS;
		mag = '0;
		if (ex == 8'hFF) begin
			r = (bits[22:0] != '0) ? 32'h0 : (sgn ? 32'h8000_0000 : 32'h7FFF_FFFF);
		end else if (ex == 8'h00) begin
			r = 32'h0;
		end else if (sh >= 8) begin
			r = sgn ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else if (sh <= -24) begin
			r = 32'h0;
		end else begin
			if (sh >= 0) begin
				mag = {8'd0, man} << sh[2:0];
			end else begin
				mag = {8'd0, man} >> 5'(-sh);
			end
			r = sgn ? -mag : mag;
		end
		return r;
	endfunction

	lfau_state_t state_q, state_d;
	logic        ld_s1, ld_s2, ld_res, slot_free;

	logic [15:0]        scale_q;
	logic signed [31:0] prev_x_q, prev_y_q, prev_h_q;
	logic signed [15:0] turn_q, turn_d;

	logic signed [31:0] dist_s1, px_s1, py_s1, hd_s1;
	logic signed [31:0] dist_s2, px_s2, py_s2, hd_s2;
	logic signed [32:0] dx_s2, dy_s2, dh_s2;
	logic signed [32:0] dx, dy, dh;

	logic               res_valid_q;
	logic signed [49:0] prod_x, prod_y, prod_h;
	logic signed [TK_W+15:0] turn_prod;
	logic signed [63:0] unw;

	assign slot_free = !res_valid_q || pop;
	assign empty     = !res_valid_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (!q_empty) state_d = ST_DIFF;
			ST_DIFF: state_d = ST_MUL;
			ST_MUL:  if (slot_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ld_s1  = 1'b0;
		ld_s2  = 1'b0;
		ld_res = 1'b0;
		unique case (state_q)
			ST_IDLE: ld_s1  = !q_empty;
			ST_DIFF: ld_s2  = 1'b1;
			ST_MUL:  ld_res = slot_free;
			default: ;
		endcase
	end

	assign q_pop = ld_s1;

	// differences and wrap detection
	assign dx = 33'(px_s1) - 33'(prev_x_q);
	assign dy = 33'(py_s1) - 33'(prev_y_q);
	assign dh = 33'(hd_s1) - 33'(prev_h_q);

	always_comb begin
		turn_d = turn_q;
		if (64'(dh) < -HALF) begin
			if (turn_q != LFAU_TURN_MAX) turn_d = turn_q + 16'sd1;
		end else if (64'(dh) > HALF) begin
			if (turn_q != LFAU_TURN_MIN) turn_d = turn_q - 16'sd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q  <= LFAU_SCALE_RST;
			prev_x_q <= '0;
			prev_y_q <= '0;
			prev_h_q <= '0;
			turn_q   <= '0;
		end else begin
			if (cfg_we) begin
				scale_q <= cfg_wdata;
			end
			if (ld_s2) begin
				prev_x_q <= px_s1;
				prev_y_q <= py_s1;
				prev_h_q <= hd_s1;
				turn_q   <= turn_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			dist_s1 <= to_fixed(q_data.rng);
			px_s1   <= to_fixed(q_data.px);
			py_s1   <= to_fixed(q_data.py);
			hd_s1   <= to_fixed(q_data.hd);
		end
		if (ld_s2) begin
			dist_s2 <= dist_s1;
			px_s2   <= px_s1;
			py_s2   <= py_s1;
			hd_s2   <= hd_s1;
			dx_s2   <= dx;
			dy_s2   <= dy;
			dh_s2   <= dh;
		end
	end

	// scaling and unwrap
	assign prod_x    = 50'(dx_s2) * signed'({1'b0, scale_q});
	assign prod_y    = 50'(dy_s2) * signed'({1'b0, scale_q});
	assign prod_h    = 50'(dh_s2) * signed'({1'b0, scale_q});
	assign turn_prod = (TK_W+16)'(turn_q) * TURN_K;
	assign unw       = 64'(turn_prod) + 64'(hd_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ld_res) begin
			res_valid_q <= 1'b1;
		end else if (pop) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_res) begin
			range_distance    <= dist_s2;
			position_x        <= px_s2;
			position_y        <= py_s2;
			heading           <= hd_s2;
			speed_x           <= lfau_sat48(64'(prod_x));
			speed_y           <= lfau_sat48(64'(prod_y));
			turn_rate         <= lfau_sat48(64'(prod_h));
			turn_count        <= turn_q;
			unwrapped_heading <= lfau_sat48(unw);
		end
	end

endmodule

/* rtl/locator_frame_angle_unwrap_top.sv */
// ----------------------------------------------------------------------------
// locator_frame_angle_unwrap_top
// Locator frame decoder with heading unwrap.
// ----------------------------------------------------------------------------
// Bytes of an 18-byte frame are pushed one per cycle; a byte is taken on every
// cycle in which full is low, and full rises only while the two-frame queue
// between the byte framer and the arithmetic back end holds two frames. The
// back end takes a frame through conversion, differences and unwrap, and scaling
// into the result register, so a result reaches the ports by way of the
// stage-one, stage-two and result registers after the edge that takes the last
// byte of a good frame, the scaling step waiting while the result slot is taken;
// the result stays on the ports until popped while the back end carries on
// with the next frame. Frames with a bad header give no result.
module locator_frame_angle_unwrap_top
	import lfau_pkg::*;
#(
	parameter int FRAC_BITS = LFAU_FRAC_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_wdata,
	input  logic                push,
	output logic                full,
	input  logic [7:0]          rx_byte,
	input  logic                frame_start,
	output logic                empty,
	input  logic                pop,
	output logic signed [31:0]  range_distance,
	output logic signed [31:0]  position_x,
	output logic signed [31:0]  position_y,
	output logic signed [31:0]  heading,
	output logic signed [47:0]  speed_x,
	output logic signed [47:0]  speed_y,
	output logic signed [47:0]  turn_rate,
	output logic signed [15:0]  turn_count,
	output logic signed [47:0]  unwrapped_heading
);

	logic        q_push, q_full, q_empty, q_pop;
	lfau_frame_t q_wdata, q_rdata;

	assign full = q_full;

	lfau_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.rx_byte     (rx_byte),
		.frame_start (frame_start),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_data      (q_wdata)
	);

	lfau_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wdata),
		.rd_en   (q_pop),
		.rd_data (q_rdata),
		.full    (q_full),
		.empty   (q_empty)
	);

	lfau_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.q_empty           (q_empty),
		.q_data            (q_rdata),
		.q_pop             (q_pop),
		.pop               (pop),
		.empty             (empty),
		.range_distance    (range_distance),
		.position_x        (position_x),
		.position_y        (position_y),
		.heading           (heading),
		.speed_x           (speed_x),
		.speed_y           (speed_y),
		.turn_rate         (turn_rate),
		.turn_count        (turn_count),
		.unwrapped_heading (unwrapped_heading)
	);

endmodule

/* rtl/lfau_checker.sv */
// ----------------------------------------------------------------------------
// lfau_checker
// Port-level checks on the result side of the locator frame block.
// ----------------------------------------------------------------------------
module lfau_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                empty,
	input  logic                pop,
	input  logic signed [31:0]  position_x,
	input  logic signed [31:0]  heading,
	input  logic signed [15:0]  turn_count,
	input  logic signed [47:0]  unwrapped_heading
);

	// a waiting item holds until popped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(position_x) && $stable(heading)
			&& $stable(turn_count) && $stable(unwrapped_heading))
		else $error("result item changed while waiting");

	// no turns counted: continuous heading is the heading itself
	a_noturn: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && turn_count == 16'sd0 |->
			unwrapped_heading == {{16{heading[31]}}, heading})
		else $error("unwrapped heading differs with zero turns");

	// turns and heading of the same sign keep that sign
	a_sign: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && turn_count[15] == heading[31] |->
			unwrapped_heading[47] == heading[31])
		else $error("unwrapped heading has wrong sign");

endmodule

bind locator_frame_angle_unwrap_top lfau_checker u_lfau_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.empty             (empty),
	.pop               (pop),
	.position_x        (position_x),
	.heading           (heading),
	.turn_count        (turn_count),
	.unwrapped_heading (unwrapped_heading)
);
